>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge out of reset
`define NKCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds whenever antecedent holds
`define NKCS_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

>>> src/nkcs_pkg.sv
// ----------------------------------------------------------------------------
// nkcs_pkg
// Types and codes of the next K-combination stepper.
// ----------------------------------------------------------------------------
package nkcs_pkg;

  localparam int POS_W = 4;
  localparam int VAL_W = 16;
  localparam int CFG_W = 5;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam logic CFG_TOTAL_COUNT  = 1'b0;
  localparam logic CFG_CHOSEN_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] TOTAL_RESET  = 5'd16;
  localparam logic [CFG_W-1:0] CHOSEN_RESET = 5'd8;

  typedef struct packed {
    logic             op;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
  } nkcs_in_t;

  typedef struct packed {
    logic [POS_W-1:0] slot;
    logic [VAL_W-1:0] element;
    logic             advanced;
    logic             final_res;
  } nkcs_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SC1_RD,
    S_SC1_CMP,
    S_SC2_RD,
    S_SC2_CMP,
    S_SW_RD,
    S_SW_W1,
    S_SW_W2,
    S_CHK,
    S_ROT,
    S_REV,
    S_EM_RD,
    S_EM_LD
  } nkcs_state_e;

  typedef enum logic [2:0] {
    PH_PIVOT,
    PH_ROT,
    PH_REV1,
    PH_REV2,
    PH_REV3,
    PH_REV4
  } nkcs_phase_e;

endpackage

>>> src/nkcs_in_if.sv
// ----------------------------------------------------------------------------
// nkcs_in_if
// Request channel: valid, ready and one input item.
// ----------------------------------------------------------------------------
interface nkcs_in_if import nkcs_pkg::*; ();
  logic     valid;
  logic     ready;
  nkcs_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/nkcs_out_if.sv
// ----------------------------------------------------------------------------
// nkcs_out_if
// Result channel: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface nkcs_out_if import nkcs_pkg::*; ();
  logic      valid;
  logic      ready;
  nkcs_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/nkcs_elem_mem.sv
// ----------------------------------------------------------------------------
// nkcs_elem_mem
// Element store: one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
module nkcs_elem_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    ra_addr_i,
  input  logic [AW-1:0]    rb_addr_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] ra_data_o,
  output logic [WIDTH-1:0] rb_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      ra_data_o <= mem_q[ra_addr_i];
      rb_data_o <= mem_q[rb_addr_i];
    end
  end

endmodule

>>> src/next_k_combination_stepper_unit.sv
// ----------------------------------------------------------------------------
// next_k_combination_stepper_unit: steps an element array to its next K-combination.
// Load writes one element. Advance: accept, read and compare per scan step, pivot swap
// (two writes), check, read and two writes per rotate or reverse swap, end of each pass,
// then a read and N results at one per cycle unless res_o stalls; one request in flight.
// Reset clears control and config (N=16, K=8); element store is not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module next_k_combination_stepper_unit import nkcs_pkg::*; #(
  parameter int MAX_ITEMS  = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  nkcs_in_if.sink          req_i,
  nkcs_out_if.source       res_o
);

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  nkcs_state_e state_q, state_d;
  nkcs_phase_e phase_q, phase_d;

  logic [CFG_W-1:0] total_q, chosen_q;
  logic [CNT_W-1:0] n_q, n_d, k_q, k_d, m1_q, m1_d, f1_q, f1_d, f2_q, f2_d;
  logic [CNT_W-1:0] a_q, a_d, b_q, b_d, lo_q, lo_d, hi_q, hi_d;
  logic [CNT_W-1:0] p_q, p_d, q_q, q_d, i_q, i_d;
  logic             adv_q, adv_d;
  logic             out_valid_q, out_valid_d;
  nkcs_out_t        out_q, out_d;

  logic [CNT_W-1:0]      n_cfg, k_cfg, m2;
  logic [CW-1:0]         tot_ext, cho_ext;
  logic                  mem_rd_en, mem_we, lt, emit_go;
  logic [IDX_W-1:0]      ra_addr, rb_addr, waddr;
  logic [VALUE_BITS-1:0] wdata, ra_data, rb_data;

  nkcs_elem_mem #(
    .DEPTH (MAX_ITEMS),
    .WIDTH (VALUE_BITS),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd_en),
    .ra_addr_i (ra_addr),
    .rb_addr_i (rb_addr),
    .we_i      (mem_we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .ra_data_o (ra_data),
    .rb_data_o (rb_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= TOTAL_RESET;
      chosen_q <= CHOSEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TOTAL_COUNT:  total_q  <= cfg_data_i;
        CFG_CHOSEN_COUNT: chosen_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign tot_ext = CW'(total_q);
  assign cho_ext = CW'(chosen_q);
  assign n_cfg   = (tot_ext > CW'(MAX_ITEMS)) ? CNT_W'(MAX_ITEMS) : CNT_W'(tot_ext);
  assign k_cfg   = (cho_ext > CW'(MAX_ITEMS)) ? CNT_W'(MAX_ITEMS) : CNT_W'(cho_ext);
  assign m2      = n_q - 1'b1;
  assign lt      = ra_data < rb_data;
  assign emit_go = !out_valid_q || res_o.ready;

  assign req_i.ready = (state_q == S_IDLE);
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_PIVOT;
      out_valid_q <= 1'b0;
      n_q  <= '0;
      k_q  <= '0;
      m1_q <= '0;
      f1_q <= '0;
      f2_q <= '0;
      a_q  <= '0;
      b_q  <= '0;
      lo_q <= '0;
      hi_q <= '0;
      p_q  <= '0;
      q_q  <= '0;
      i_q  <= '0;
      adv_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      n_q  <= n_d;
      k_q  <= k_d;
      m1_q <= m1_d;
      f1_q <= f1_d;
      f2_q <= f2_d;
      a_q  <= a_d;
      b_q  <= b_d;
      lo_q <= lo_d;
      hi_q <= hi_d;
      p_q  <= p_d;
      q_q  <= q_d;
      i_q  <= i_d;
      adv_q <= adv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    n_d  = n_q;
    k_d  = k_q;
    m1_d = m1_q;
    f1_d = f1_q;
    f2_d = f2_q;
    a_d  = a_q;
    b_d  = b_q;
    lo_d = lo_q;
    hi_d = hi_q;
    p_d  = p_q;
    q_d  = q_q;
    i_d  = i_q;
    adv_d = adv_q;
    out_d = out_q;
    out_valid_d = out_valid_q && !res_o.ready;
    mem_rd_en = 1'b0;
    ra_addr   = p_q[IDX_W-1:0];
    rb_addr   = q_q[IDX_W-1:0];
    mem_we    = 1'b0;
    waddr     = p_q[IDX_W-1:0];
    wdata     = rb_data;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_i.data.op == OP_LOAD) begin
            if (32'(req_i.data.position) < MAX_ITEMS) begin
              mem_we = 1'b1;
              waddr  = IDX_W'(req_i.data.position);
              wdata  = VALUE_BITS'(req_i.data.value);
            end
          end else begin
            n_d  = n_cfg;
            k_d  = k_cfg;
            i_d  = '0;
            f1_d = '0;
            f2_d = k_cfg;
            m1_d = k_cfg - 1'b1;
            if (n_cfg == '0) begin
              state_d = S_IDLE;
            end else if (k_cfg == '0 || k_cfg >= n_cfg) begin
              adv_d   = 1'b0;
              state_d = S_EM_RD;
            end else begin
              state_d = S_SC1_RD;
            end
          end
        end
      end
      S_SC1_RD: begin
        mem_rd_en = 1'b1;
        ra_addr   = m1_q[IDX_W-1:0];
        rb_addr   = m2[IDX_W-1:0];
        state_d   = S_SC1_CMP;
      end
      S_SC1_CMP: begin
        if (m1_q != '0 && !lt) begin
          m1_d    = m1_q - 1'b1;
          state_d = S_SC1_RD;
        end else if (!lt) begin
          // wrap: already the last combination
          adv_d   = 1'b0;
          state_d = S_CHK;
        end else begin
          adv_d   = 1'b1;
          state_d = S_SC2_RD;
        end
      end
      S_SC2_RD: begin
        mem_rd_en = 1'b1;
        ra_addr   = m1_q[IDX_W-1:0];
        rb_addr   = f2_q[IDX_W-1:0];
        state_d   = S_SC2_CMP;
      end
      S_SC2_CMP: begin
        if (f2_q != m2 && !lt) begin
          f2_d    = f2_q + 1'b1;
          state_d = S_SC2_RD;
        end else begin
          // read data already holds both operands of the pivot swap
          p_d     = m1_q;
          q_d     = f2_q;
          f1_d    = m1_q + 1'b1;
          f2_d    = f2_q + 1'b1;
          phase_d = PH_PIVOT;
          state_d = S_SW_W1;
        end
      end
      S_SW_RD: begin
        mem_rd_en = 1'b1;
        state_d   = S_SW_W1;
      end
      S_SW_W1: begin
        mem_we  = 1'b1;
        waddr   = p_q[IDX_W-1:0];
        wdata   = rb_data;
        state_d = S_SW_W2;
      end
      S_SW_W2: begin
        mem_we = 1'b1;
        waddr  = q_q[IDX_W-1:0];
        wdata  = ra_data;
        case (phase_q)
          PH_PIVOT: state_d = S_CHK;
          PH_ROT:   state_d = S_ROT;
          default:  state_d = S_REV;
        endcase
      end
      S_CHK: begin
        if (f1_q != k_q && f2_q != n_q) begin
          a_d     = k_q;
          b_d     = f2_q;
          state_d = S_ROT;
        end else begin
          i_d     = '0;
          state_d = S_EM_RD;
        end
      end
      S_ROT: begin
        if (a_q != f1_q && b_q != n_q) begin
          p_d     = a_q - 1'b1;
          q_d     = b_q;
          a_d     = a_q - 1'b1;
          b_d     = b_q + 1'b1;
          phase_d = PH_ROT;
          state_d = S_SW_RD;
        end else begin
          lo_d    = f1_q;
          hi_d    = a_q;
          phase_d = PH_REV1;
          state_d = S_REV;
        end
      end
      S_REV: begin
        if ((CNT_W + 1)'(lo_q) + 1'b1 < (CNT_W + 1)'(hi_q)) begin
          p_d     = lo_q;
          q_d     = hi_q - 1'b1;
          lo_d    = lo_q + 1'b1;
          hi_d    = hi_q - 1'b1;
          state_d = S_SW_RD;
        end else begin
          case (phase_q)
            PH_REV1: begin
              lo_d    = f1_q;
              hi_d    = k_q;
              phase_d = PH_REV2;
            end
            PH_REV2: begin
              lo_d    = b_q;
              hi_d    = n_q;
              phase_d = PH_REV3;
            end
            PH_REV3: begin
              lo_d    = f2_q;
              hi_d    = n_q;
              phase_d = PH_REV4;
            end
            default: begin
              i_d     = '0;
              state_d = S_EM_RD;
            end
          endcase
        end
      end
      S_EM_RD: begin
        mem_rd_en = 1'b1;
        ra_addr   = i_q[IDX_W-1:0];
        state_d   = S_EM_LD;
      end
      S_EM_LD: begin
        if (emit_go) begin
          out_valid_d     = 1'b1;
          out_d.slot      = POS_W'(i_q);
          out_d.element   = VAL_W'(ra_data);
          out_d.advanced  = adv_q;
          out_d.final_res = (i_q == m2);
          if (i_q == m2) begin
            state_d = S_IDLE;
          end else begin
            i_d       = i_q + 1'b1;
            mem_rd_en = 1'b1;
            ra_addr   = i_d[IDX_W-1:0];
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `NKCS_ASSERT_IMPL(a_swap_in_range,
    state_q == S_SW_RD || state_q == S_SW_W1 || state_q == S_SW_W2,
    p_q < n_q && q_q < n_q, "swap pointer beyond N")
  `NKCS_ASSERT_IMPL(a_scan_in_range, state_q == S_SC1_RD || state_q == S_SC1_CMP,
    m1_q < k_q && k_q < n_q, "pivot scan outside chosen part")
  `NKCS_ASSERT_IMPL(a_write_source, mem_we,
    state_q == S_IDLE || state_q == S_SW_W1 || state_q == S_SW_W2,
    "element store written outside load or swap")
  `NKCS_ASSERT(a_emit_in_range, !(state_q == S_EM_LD) || i_q < n_q, "emit slot beyond N")

endmodule
